FILE: rtl/modexp_pkg.sv
package modexp_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word addend;
        t_word mult;
    } t_mm_req;

    typedef struct packed {
        logic  done;
        t_word result;
    } t_mm_rsp;

endpackage

FILE: rtl/modular_exponentiation.sv
// Channel | Valid       | Stall       | Payload
// --------+-------------+-------------+-------------------------------
// cfg     | i_cfg_wr_en | -           | i_cfg_wr_data (modulus)
// in      | i_in_valid  | o_in_stall  | i_base_value, i_exponent
// out     | o_out_valid | i_out_stall | o_power_mod, o_error
//
// A zero modulus or zero exponent skips the multiplier; otherwise each beat runs
// a reduction of the base and then its squarings and multiplies on the shared
// bit-serial modular multiplier that takes one multiplier bit per cycle.
// Reset is synchronous, active low, and loads the modulus with 1.
// A new input beat is taken while an earlier result waits on a stalled output.
module modular_exponentiation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [modexp_pkg::WORD_BITS-1:0]   i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [modexp_pkg::WORD_BITS-1:0]   i_base_value,
    input  logic [modexp_pkg::WORD_BITS-1:0]   i_exponent,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [modexp_pkg::WORD_BITS-1:0]   o_power_mod,
    output logic                               o_error
);

    localparam int W = modexp_pkg::WORD_BITS;
    localparam modexp_pkg::t_word ONE = modexp_pkg::t_word'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    modexp_pkg::t_word   r_modulus;
    modexp_pkg::t_word   r_exp, n_exp;
    modexp_pkg::t_word   r_b, n_b;
    modexp_pkg::t_word   r_r, n_r;
    modexp_pkg::t_word   r_res, n_res;
    logic                r_err, n_err;
    logic                r_out_valid, n_out_valid;
    modexp_pkg::t_word   r_out_pm, n_out_pm;
    logic                r_out_err, n_out_err;

    modexp_pkg::t_mm_req mm_req;
    modexp_pkg::t_mm_rsp mm_rsp;

    modexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (mm_req),
        .o_rsp     (mm_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_b         = r_b;
        n_r         = r_r;
        n_res       = r_res;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pm    = r_out_pm;
        n_out_err   = r_out_err;
        mm_req      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_modulus == '0) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else if (i_exponent == '0) begin
                        n_res   = ONE;
                        n_err   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_exp         = i_exponent;
                        mm_req.start  = 1'b1;
                        mm_req.addend = ONE;
                        mm_req.mult   = i_base_value;
                        n_state       = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_rsp.done) begin
                    n_b          = mm_rsp.result;
                    n_r          = ONE;
                    mm_req.start = 1'b1;
                    mm_req.mult  = mm_rsp.result;
                    if (r_exp[0]) begin
                        mm_req.addend = ONE;
                        n_state       = S_MUL;
                    end else begin
                        mm_req.addend = mm_rsp.result;
                        n_state       = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    n_r = mm_rsp.result;
                    if (r_exp[W-1:1] == '0) begin
                        n_res   = mm_rsp.result;
                        n_err   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        mm_req.start  = 1'b1;
                        mm_req.addend = r_b;
                        mm_req.mult   = r_b;
                        n_state       = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_rsp.done) begin
                    n_b          = mm_rsp.result;
                    n_exp        = {1'b0, r_exp[W-1:1]};
                    mm_req.start = 1'b1;
                    mm_req.mult  = mm_rsp.result;
                    if (r_exp[1]) begin
                        mm_req.addend = r_r;
                        n_state       = S_MUL;
                    end else begin
                        mm_req.addend = mm_rsp.result;
                        n_state       = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_pm    = r_res;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= ONE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_modulus <= i_cfg_wr_data;
            end
        end
        r_exp     <= n_exp;
        r_b       <= n_b;
        r_r       <= n_r;
        r_res     <= n_res;
        r_err     <= n_err;
        r_out_pm  <= n_out_pm;
        r_out_err <= n_out_err;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_out_pm;
    assign o_error     = r_out_err;

endmodule

FILE: rtl/modexp_mulmod.sv
module modexp_mulmod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  modexp_pkg::t_word   i_modulus,
    input  modexp_pkg::t_mm_req i_req,
    output modexp_pkg::t_mm_rsp o_rsp
);

    localparam int W = modexp_pkg::WORD_BITS;

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [modexp_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    modexp_pkg::t_word             r_acc, n_acc;
    modexp_pkg::t_word             r_addend, n_addend;
    modexp_pkg::t_word             r_bits, n_bits;

    logic [W+2:0] sum;
    logic [W+2:0] diff1;
    logic [W+2:0] diff2;

    always_comb begin
        sum   = {2'b00, r_acc, 1'b0} + {3'b000, (r_bits[W-1] ? r_addend : '0)};
        diff1 = sum - {3'b000, i_modulus};
        diff2 = sum - {2'b00, i_modulus, 1'b0};
    end

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_addend = r_addend;
        n_bits   = r_bits;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_acc    = '0;
            n_addend = i_req.addend;
            n_bits   = i_req.mult;
        end else if (r_busy) begin
            if (!diff2[W+2]) begin
                n_acc = diff2[W-1:0];
            end else if (!diff1[W+2]) begin
                n_acc = diff1[W-1:0];
            end else begin
                n_acc = sum[W-1:0];
            end
            n_bits = {r_bits[W-2:0], 1'b0};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == modexp_pkg::CNT_BITS'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_addend <= n_addend;
        r_bits   <= n_bits;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

FILE: rtl/modexp_checker.sv
module modexp_sva (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [modexp_pkg::WORD_BITS-1:0] o_power_mod,
    input logic                             o_error
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_power_mod == '0)
        else $error("error beat with nonzero power_mod");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_power_mod) && $stable(o_error))
        else $error("stalled output beat changed");

endmodule

bind modular_exponentiation modexp_sva u_modexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_power_mod (o_power_mod),
    .o_error     (o_error)
);

FILE: sim/modexp_checker.sv
`timescale 1ns / 100ps

module modexp_checker
    import modexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr_en,
    input  t_word i_cfg_wr_data,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_word i_base_value,
    input  t_word i_exponent,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_word i_power_mod,
    input  logic  i_error,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct {
        t_word power_mod;
        logic  error;
    } t_power_result;

    t_word         modulus_copy;
    t_power_result expected_power_q[$];

    function automatic t_word power_modulo(t_word base_value, t_word exponent, t_word m);
        logic [127:0] acc;
        logic [127:0] sq;
        t_word        e;
        acc = 128'd1;
        e   = exponent;
        if (e == '0) begin
            return t_word'(1);
        end
        sq = base_value % m;
        while (e != '0) begin
            if (e[0]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[WORD_BITS-1:0];
    endfunction

    function automatic t_power_result predict_power(t_word base_value, t_word exponent);
        t_power_result res;
        if (modulus_copy == '0) begin
            res.power_mod = '0;
            res.error     = 1'b1;
        end else begin
            res.power_mod = power_modulo(base_value, exponent, modulus_copy);
            res.error     = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_power_result want;
        if (!i_rst_n) begin
            modulus_copy = t_word'(1);
            expected_power_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                modulus_copy = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_power_q.push_back(predict_power(i_base_value, i_exponent));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_power_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_power_mod, '0);
                end else begin
                    want = expected_power_q.pop_front();
                    if (i_power_mod !== want.power_mod) begin
                        report_mismatch("power_mod", i_power_mod, want.power_mod);
                    end
                    if (i_error !== want.error) begin
                        report_mismatch("error", t_word'(i_error), t_word'(want.error));
                    end
                end
            end
        end
        o_pending <= expected_power_q.size();
    end

endmodule

FILE: sim/modular_exponentiation_tb.sv
`timescale 1ns / 100ps

module modular_exponentiation_tb;
    import modexp_pkg::*;

    localparam int    QUIET_LIMIT = 40000;
    localparam t_word WORD_MAX    = {WORD_BITS{1'b1}};

    logic  i_clk         = 1'b0;
    logic  i_rst_n       = 1'b0;
    logic  i_cfg_wr_en   = 1'b0;
    t_word i_cfg_wr_data = '0;
    logic  i_in_valid    = 1'b0;
    logic  o_in_stall;
    t_word i_base_value  = '0;
    t_word i_exponent    = '0;
    logic  o_out_valid;
    logic  i_out_stall   = 1'b0;
    t_word o_power_mod;
    logic  o_error;

    int    fail_count;
    int    pending;
    logic  calm        = 1'b0;
    int    cycle_count = 0;
    int    stall_left  = 0;
    int    quiet       = 0;

    modular_exponentiation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_base_value  (i_base_value),
        .i_exponent    (i_exponent),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_power_mod   (o_power_mod),
        .o_error       (o_error)
    );

    modexp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_base_value  (i_base_value),
        .i_exponent    (i_exponent),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_power_mod   (o_power_mod),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic t_word random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic t_word random_exponent();
        int    r;
        int    len;
        t_word e;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end
        if (r < 16) begin
            return random_word();
        end
        len = $urandom_range(1, 12);
        e   = random_word() & ((t_word'(1) << len) - 1);
        return e | (t_word'(1) << (len - 1));
    endfunction

    function automatic t_word random_base(t_word m);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return random_word();
        end
        if (r < 70) begin
            return t_word'($urandom_range(0, 255));
        end
        if (r < 80) begin
            return t_word'($urandom_range(0, 1));
        end
        if (r < 90) begin
            return m - 1;
        end
        return WORD_MAX;
    endfunction

    // out-side stall bursts; calm stretches drop idling on both sides
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 1000 == 0) begin
            calm <= ($urandom_range(0, 3) == 0);
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            stall_left  <= idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("modular_exponentiation regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_modulus(t_word m);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_beat(t_word base_value, t_word exponent);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= base_value;
        i_exponent   <= exponent;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic random_phase(t_word m, int count);
        load_modulus(m);
        repeat (count) send_beat(random_base(m), random_exponent());
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // modulus still at its reset value of one
        send_beat(64'd7, '0);
        send_beat(WORD_MAX, WORD_MAX);
        send_beat(64'd9, 64'd1);
        i_in_valid <= 1'b0;

        load_modulus('0);
        send_beat(64'd5, 64'd3);
        send_beat('0, '0);
        send_beat(WORD_MAX, WORD_MAX);
        i_in_valid <= 1'b0;

        load_modulus(WORD_MAX);
        send_beat(WORD_MAX, '0);
        send_beat(WORD_MAX, 64'd1);
        send_beat(WORD_MAX - 1, 64'd1);
        send_beat(WORD_MAX - 1, WORD_MAX);
        send_beat('0, '0);
        send_beat('0, WORD_MAX);
        send_beat(64'd2, 64'd63);
        send_beat(64'd2, 64'd64);
        send_beat(64'd1, WORD_MAX);
        i_in_valid <= 1'b0;

        load_modulus(64'd1000000007);
        send_beat(64'd123456789, 64'd1000000006);
        send_beat(random_word(), 64'd2);
        send_beat(64'd1000000007, 64'd5);
        i_in_valid <= 1'b0;

        load_modulus(64'd2);
        send_beat(64'd3, WORD_MAX);
        send_beat(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        i_in_valid <= 1'b0;

        random_phase(random_word() | (t_word'(1) << 63), 16);
        random_phase({32'd1, $urandom}, 14);
        random_phase(t_word'($urandom_range(2, 65535)), 14);
        random_phase(64'hFFFF_FFFF_FFFF_FFC5, 14);
        random_phase(t_word'(1), 12);
        random_phase('0, 10);
        random_phase(t_word'(1) << 63, 10);
        random_phase(random_word(), 12);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("modular_exponentiation regression: pass");
        end else begin
            $display("modular_exponentiation regression: fail");
        end
        $finish;
    end

endmodule
